/* rtl/itra_pkg.sv */
// shared types, constants and helpers for the integer to radix text converter
// no dependencies; imported by itra_ctrl, itra_datapath and integer_to_radix_ascii

package itra_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int STEP_BITS      = 8;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN     = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic rd;
    logic out_load;
    logic out_sign;
    logic out_last;
  } itra_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic quo_zero;
    logic negative;
    logic out_free;
  } itra_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DIGIT_MAX_DEC) begin
      return CHAR_LOWER_A + dw - DIGIT_TEN;
    end
    return CHAR_ZERO + dw;
  endfunction

endpackage

/* rtl/itra_datapath.sv */
// datapath: radix register, shift-subtract divider, digit stack and output register
// depends on itra_pkg

module itra_datapath #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itra_pkg::RADIX_W-1:0]   cfg_wdata_i,
  input  logic [VALUE_BITS-1:0]          value_i,
  input  itra_pkg::itra_cmd_t            cmd_i,
  input  logic [$clog2(VALUE_BITS)-1:0]  mem_idx_i,
  output itra_pkg::itra_status_t         status_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [itra_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_char_o
);
  import itra_pkg::*;

  localparam int NCYC = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD  = NCYC * STEP_BITS;

  logic [RADIX_W-1:0]    radix_q;
  logic [RADIX_W-1:0]    base_q;
  logic [RADIX_W-1:0]    base_cl;
  logic                  neg_q;
  logic                  neg_d;
  logic [PAD-1:0]        shreg_q;
  logic [PAD-1:0]        shreg_d;
  logic [RADIX_W-1:0]    rem_q;
  logic [RADIX_W-1:0]    rem_d;
  logic [STEP_BITS-1:0]  quo_bits;
  logic [RADIX_W:0]      rem_w;
  logic [VALUE_BITS-1:0] mag;
  logic [CHAR_W-1:0]     rd_q;
  logic                  out_valid_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;
  logic [CHAR_W-1:0]     stack_mem [VALUE_BITS];

  // clamp radix into 2..36
  always_comb begin
    base_cl = radix_q;
    if (radix_q < RADIX_MIN) begin
      base_cl = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base_cl = RADIX_MAX;
    end
  end

  assign neg_d = (base_cl == RADIX_DEC) && value_i[VALUE_BITS-1];
  assign mag   = neg_d ? (~value_i + 1'b1) : value_i;

  // several restoring steps per cycle on a narrow remainder
  always_comb begin
    rem_w    = {1'b0, rem_q};
    quo_bits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_w = {rem_w[RADIX_W-1:0], shreg_q[PAD-1-i]};
      if (rem_w >= {1'b0, base_q}) begin
        rem_w = rem_w - {1'b0, base_q};
        quo_bits[STEP_BITS-1-i] = 1'b1;
      end
    end
    rem_d   = rem_w[RADIX_W-1:0];
    shreg_d = (shreg_q << STEP_BITS) | PAD'(quo_bits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        neg_q <= neg_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q  <= base_cl;
      shreg_q <= PAD'(mag);
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end else if (cmd_i.push) begin
      rem_q <= '0;
    end
    if (cmd_i.out_load) begin
      char_q <= cmd_i.out_sign ? CHAR_MINUS : rd_q;
      last_q <= cmd_i.out_last;
    end
  end

  // digit stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[mem_idx_i] <= digit_char(rem_q);
    end
    if (cmd_i.rd) begin
      rd_q <= stack_mem[mem_idx_i];
    end
  end

  assign status_o.quo_zero = (shreg_q == '0);
  assign status_o.negative = neg_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

/* rtl/itra_ctrl.sv */
// controller: sequences load, division steps, digit pushes and character output
// depends on itra_pkg

module itra_ctrl #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  itra_pkg::itra_status_t        status_i,
  output itra_pkg::itra_cmd_t           cmd_o,
  output logic [$clog2(VALUE_BITS)-1:0] mem_idx_o
);
  import itra_pkg::*;

  localparam int NCYC   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int STEP_W = $clog2(NCYC + 1);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int IDX_W  = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_m1;

  assign count_m1   = count_q - 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign mem_idx_o  = (state_q == S_PUSH) ? count_q[IDX_W-1:0] : count_m1[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          count_d    = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(NCYC - 1)) begin
          step_d  = '0;
          state_d = S_PUSH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        count_d    = count_q + 1'b1;
        if (status_i.quo_zero) begin
          state_d = status_i.negative ? S_SIGN : S_READ;
        end else begin
          state_d = S_DIV;
        end
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sign = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (count_q == CNT_W'(1));
          count_d        = count_m1;
          state_d        = (count_q == CNT_W'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/integer_to_radix_ascii.sv */
// integer to radix text: one word in, its ascii digits out, most significant first
// sequence: a load, division steps and a push per digit, a '-' beat if negative,
// then a stack read and an emit per character
// throughput: one word at a time; a new word is taken once the last character is loaded
// reset: asynchronous active-low rst_ni; radix returns to ten, controller idles
// depends on itra_pkg, itra_ctrl, itra_datapath

module integer_to_radix_ascii #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // radix register write, no read-back
  input  logic                         cfg_we_i,
  input  logic [itra_pkg::RADIX_W-1:0] cfg_wdata_i,
  // input beat: one word, two's complement in base ten, unsigned in other bases
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [VALUE_BITS-1:0]        value_i,
  // output beat: one character
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [itra_pkg::CHAR_W-1:0]  character_o,
  output logic                         last_char_o
);
  import itra_pkg::*;

  itra_cmd_t                     cmd;
  itra_status_t                  status;
  logic [$clog2(VALUE_BITS)-1:0] mem_idx;

  // the controller walks each word through: load (sign fold in base ten),
  // repeated division by the clamped radix with the divider retiring 8
  // quotient bits a cycle, a push of each remainder digit onto the stack
  // until the quotient reaches zero, then an optional '-' beat and a pop of
  // the stack in reverse order; zero falls out as a single '0' digit
  itra_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .mem_idx_o  (mem_idx)
  );

  // the output register lets the last character of one word wait on the
  // consumer while the next word is already being divided
  itra_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .mem_idx_i   (mem_idx),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

/* tb/integer_to_radix_ascii_tb.sv */
// self-checking bench for integer_to_radix_ascii: words in, ascii digit beats out
// depends on itra_pkg and the integer_to_radix_ascii rtl

`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;

  import itra_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 26;
  localparam int SETTLE_TICKS = 40;

  // one expected character beat
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [RADIX_W-1:0]  cfg_wdata_i  = RADIX_RESET;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [31:0]         value_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [CHAR_W-1:0]   character_o;
  logic                last_char_o;

  // bench state
  logic [31:0]         pending_words[$];
  glyph_t              expected_text[$];
  logic [RADIX_W-1:0]  radix_shadow = RADIX_RESET;
  int                  tx_idle_pct  = 0;
  int                  rx_idle_pct  = 0;
  logic                hold_kick    = 1'b0;
  int                  hold_left    = 0;
  int                  errors       = 0;
  int                  cycles       = 0;

  integer_to_radix_ascii u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // expected text of one word under the current radix, pushed onto expected_text
  function automatic void spell_word(input logic [31:0] word);
    logic [RADIX_W-1:0] base;
    logic [31:0]        mag;
    logic [31:0]        d;
    logic               neg;
    logic [CHAR_W-1:0]  digits[$];
    glyph_t             g;
    // out-of-range radix settings clamp to the nearest legal base
    base = radix_shadow;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    // sign only matters in base ten; the most negative word wraps to its own magnitude
    neg = (base == RADIX_DEC) && word[31];
    mag = neg ? (32'd0 - word) : word;
    if (mag == 32'd0) begin
      digits.push_back(CHAR_ZERO);
    end else begin
      while (mag != 32'd0) begin
        d = mag % 32'(base);
        if (d < 32'd10) begin
          digits.push_front(CHAR_ZERO + d[CHAR_W-1:0]);
        end else begin
          digits.push_front(CHAR_LOWER_A + d[CHAR_W-1:0] - 8'd10);
        end
        mag = mag / 32'(base);
      end
      if (neg) digits.push_front(CHAR_MINUS);
    end
    foreach (digits[i]) begin
      g.code = digits[i];
      g.last = (i == digits.size() - 1);
      expected_text.push_back(g);
    end
  endfunction

  // random word, biased toward small magnitudes, edges and powers of two
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'($urandom_range(2000));
      1: return 32'd0 - 32'($urandom_range(2000, 1));
      2: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hffff_ffff;
          3: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      3: return (32'd1 << $urandom_range(31)) + 32'($urandom_range(2)) - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // sender: holds a beat until it is taken, may idle only when launching a new one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      // beat accepted at this edge: predict its text now, under the live radix
      if (in_valid_i) spell_word(value_i);
      if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        value_i    <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off that backs up the block
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (hold_kick) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall_i <= hold_kick || (hold_left > 1) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // checker: each accepted character beat against the oldest expected one
  always @(posedge clk_i) begin
    glyph_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected nothing, got char %h last %b",
                 $time, character_o, last_char_o);
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.code) begin
          errors++;
          $display("%0t: character expected %h got %h", $time, want.code, character_o);
        end
        if (last_char_o !== want.last) begin
          errors++;
          $display("%0t: last_char expected %b got %b", $time, want.last, last_char_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("integer_to_radix_ascii: mismatch");
      $finish;
    end
  end

  // wait until every queued word is sent and every character has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_text.size() != 0);
  endtask

  // radix write while the block is idle; shadow copy is set on the edge that raises cfg_we_i
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= r;
    radix_shadow <= r;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    @(negedge clk_i);
  endtask

  // sequence of radix settings: extremes, clamped out-of-range codes, a few random
  logic [RADIX_W-1:0] radix_plan[14];

  initial begin
    radix_plan = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd37, 6'd10, 6'd1,
                   6'd63, 6'd8, 6'd3, 6'd10, 6'd35, 6'd0, 6'd0};
    radix_plan[12] = 6'($urandom_range(36, 2));
    radix_plan[13] = 6'($urandom_range(63));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, base ten from reset: zero, signs, extremes, most negative word
    tx_idle_pct = 27;
    rx_idle_pct = 61;
    pending_words = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, 32'hffff_fff6,
                      32'h7fff_ffff, 32'h8000_0000, 32'd123456789, 32'hc521_97cf,
                      32'd1000000000, 32'h8000_0001};
    wait_drained();

    foreach (radix_plan[p]) begin
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (p < 5) begin
        tx_idle_pct = 27;
        rx_idle_pct = 61;
      end else if (p < 10) begin
        tx_idle_pct = 61;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_radix(radix_plan[p]);
      // base two: longest texts, top bit alone; base 36: last letter and first carry
      if (p == 0) pending_words = '{32'd0, 32'd1, 32'hffff_ffff, 32'h8000_0000};
      if (p == 1) pending_words = '{32'd35, 32'd36, 32'hffff_ffff, 32'd0};
      repeat (PHASE_WORDS) pending_words.push_back(pick_word());
      // long receiver hold-off while the sender keeps offering words
      if (p == 5 || p == 10) begin
        @(posedge clk_i);
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      wait_drained();
    end

    // let any stray beat show up before the verdict
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (errors == 0) begin
      $display("integer_to_radix_ascii: match");
    end else begin
      $display("integer_to_radix_ascii: mismatch");
    end
    $finish;
  end

endmodule
